/* sv/pea_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pea_pkg
// shared widths, types and defaults for the percentage error accumulator
// ----------------------------------------------------------------------------
package pea_pkg;

   localparam int DATA_W        = 32;   // signed q16.16 sample width
   localparam int NUM_W         = 33;   // numerator / denominator width
   localparam int RATIO_W       = 32;   // per-sample ratio width
   localparam int SUM_W         = 48;   // ratio accumulator width
   localparam int PCT_W         = 40;   // mean percentage width
   localparam int COUNT_OUT_W   = 17;   // reported sample count width
   localparam int PCT_SCALE_W   = SUM_W + 7;  // sum times one hundred

   localparam int DEF_FRAC_BITS   = 16;
   localparam int DEF_MAX_SAMPLES = 65536;

   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W       = $clog2(QUEUE_DEPTH + 1);

   // metric selection
   localparam logic MODE_PLAIN     = 1'b0;
   localparam logic MODE_SYMMETRIC = 1'b1;

   // classified sample passed from front to back
   typedef struct packed {
      logic [DATA_W-1:0] a_mag;
      logic [DATA_W-1:0] p_mag;
      logic [DATA_W-1:0] d_mag;
      logic              mode;
      logic              skip;
      logic              last;
   } sample_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREP,
      BK_RATIO,
      BK_END,
      BK_PCT,
      BK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

/* sv/pea_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pea_front
// takes magnitudes of the sample pair and flags zero-denominator samples
// ----------------------------------------------------------------------------
module pea_front import pea_pkg::*; (
   input  wire logic                     metric_mode,
   input  wire logic signed [DATA_W-1:0] actual_value,
   input  wire logic signed [DATA_W-1:0] predicted_value,
   input  wire logic                     series_end,
   output sample_type                    sample
);

   logic [DATA_W-1:0] a_raw;
   logic [DATA_W-1:0] p_raw;
   logic [DATA_W:0]   diff;
   logic              a_zero;
   logic              p_zero;

   assign a_raw  = actual_value;
   assign p_raw  = predicted_value;
   // 33-bit difference, never overflows
   assign diff   = {a_raw[DATA_W-1], a_raw} - {p_raw[DATA_W-1], p_raw};
   assign a_zero = (a_raw == '0);
   assign p_zero = (p_raw == '0);

   always_comb begin
      sample.a_mag = a_raw[DATA_W-1] ? (~a_raw + 1'b1) : a_raw;
      sample.p_mag = p_raw[DATA_W-1] ? (~p_raw + 1'b1) : p_raw;
      sample.d_mag = diff[DATA_W] ? DATA_W'(~diff + 1'b1) : diff[DATA_W-1:0];
      sample.mode  = metric_mode;
      // denominator zero: |a| alone, or |a|+|p|
      sample.skip  = (metric_mode == MODE_SYMMETRIC) ? (a_zero && p_zero) : a_zero;
      sample.last  = series_end;
   end

endmodule

`default_nettype wire

/* sv/pea_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pea_queue
// short fifo of classified samples between front and back
// ----------------------------------------------------------------------------
module pea_queue import pea_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire sample_type push_data,
   output logic            full,
   input  wire logic       pop,
   output logic            not_empty,
   output sample_type      pop_data
);

   sample_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* sv/pea_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pea_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pea_div import pea_pkg::*; #(
   parameter int DVD_W = PCT_SCALE_W,
   parameter int DVS_W = NUM_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(DVD_W);

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    shifted;
   logic [DVS_W:0]    trial;

   assign shifted  = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial    = shifted - {1'b0, dvs_ff};
   assign done     = done_ff;
   // quotient bits shift in behind the dividend
   assign quotient = dvd_ff;

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DVS_W]) begin
            rem_in = trial[DVS_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DVS_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

endmodule

`default_nettype wire

/* sv/pea_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pea_back
// per-sample ratio, accumulation and end-of-series mean with result register
// ----------------------------------------------------------------------------
module pea_back import pea_pkg::*; #(
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_not_empty,
   input  wire sample_type             q_data,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [PCT_W-1:0]            rsp_error_percent,
   output logic                        rsp_result_defined,
   output logic [COUNT_OUT_W-1:0]      rsp_samples_used
);

   localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int RDVD_W  = NUM_W + FRAC_BITS;
   localparam int DVD_W   = (RDVD_W > PCT_SCALE_W) ? RDVD_W : PCT_SCALE_W;
   localparam int DVS_W   = (CNT_W > NUM_W) ? CNT_W : NUM_W;

   back_state_type state_ff, state_in;

   sample_type         smp_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PCT_W-1:0]   pct_ff;
   logic               rsp_valid_ff;
   logic [PCT_W-1:0]   rsp_pct_ff;
   logic               rsp_def_ff;
   logic [COUNT_OUT_W-1:0] rsp_cnt_ff;

   logic               count_full;
   logic               count_zero;
   logic               slot_free;
   logic               start_ratio;
   logic               start_pct;
   logic               acc_en;
   logic               pct_en;
   logic               emit;

   logic [NUM_W-1:0]   num;
   logic [NUM_W-1:0]   den;
   logic [DVD_W-1:0]   div_dividend;
   logic [DVS_W-1:0]   div_divisor;
   logic               div_done;
   logic [DVD_W-1:0]   div_quot;
   logic [RATIO_W-1:0] ratio;
   logic [SUM_W:0]     sum_add;
   logic [DVD_W-1:0]   sum_x100;

   assign count_full = (count_ff >= CNT_W'(MAX_SAMPLES));
   assign count_zero = (count_ff == '0);
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // numerator and denominator of the selected metric
   always_comb begin
      if (smp_ff.mode == MODE_SYMMETRIC) begin
         num = {smp_ff.d_mag, 1'b0};
         den = {1'b0, smp_ff.a_mag} + {1'b0, smp_ff.p_mag};
      end else begin
         num = {1'b0, smp_ff.d_mag};
         den = {1'b0, smp_ff.a_mag};
      end
   end

   // sum * 100 as 64 + 32 + 4
   assign sum_x100 = DVD_W'({sum_ff, 6'b0}) + DVD_W'({sum_ff, 5'b0})
                   + DVD_W'({sum_ff, 2'b0});

   always_comb begin
      if (start_pct) begin
         div_dividend = sum_x100;
         div_divisor  = DVS_W'(count_ff);
      end else begin
         div_dividend = DVD_W'({num, {FRAC_BITS{1'b0}}});
         div_divisor  = DVS_W'(den);
      end
   end

   pea_div #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ratio || start_pct),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ratio saturates at its 32-bit maximum, sum at 48 bits
   assign ratio   = (|div_quot[DVD_W-1:RATIO_W]) ? '1 : div_quot[RATIO_W-1:0];
   assign sum_add = {1'b0, sum_ff} + (SUM_W + 1)'(ratio);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_not_empty) state_in = BK_PREP;
         end
         BK_PREP: begin
            if (smp_ff.skip || count_full) state_in = BK_END;
            else                           state_in = BK_RATIO;
         end
         BK_RATIO: begin
            if (div_done) state_in = BK_END;
         end
         BK_END: begin
            if (!smp_ff.last)    state_in = BK_IDLE;
            else if (count_zero) state_in = BK_EMIT;
            else                 state_in = BK_PCT;
         end
         BK_PCT: begin
            if (div_done) state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (slot_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop       = 1'b0;
      start_ratio = 1'b0;
      start_pct   = 1'b0;
      acc_en      = 1'b0;
      pct_en      = 1'b0;
      emit        = 1'b0;
      unique case (state_ff)
         BK_IDLE:  q_pop       = q_not_empty;
         BK_PREP:  start_ratio = !smp_ff.skip && !count_full;
         BK_RATIO: acc_en      = div_done;
         BK_END:   start_pct   = smp_ff.last && !count_zero;
         BK_PCT:   pct_en      = div_done;
         BK_EMIT:  emit        = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (emit) begin
         sum_in   = '0;
         count_in = '0;
      end else if (acc_en) begin
         sum_in   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         if (emit)           rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         smp_ff <= q_data;
      end
      if (pct_en) begin
         pct_ff <= (|div_quot[DVD_W-1:PCT_W]) ? '1 : div_quot[PCT_W-1:0];
      end
      if (emit) begin
         rsp_pct_ff <= count_zero ? '0 : pct_ff;
         rsp_def_ff <= !count_zero;
         rsp_cnt_ff <= COUNT_OUT_W'(count_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_error_percent  = rsp_pct_ff;
   assign rsp_result_defined = rsp_def_ff;
   assign rsp_samples_used   = rsp_cnt_ff;

endmodule

`default_nettype wire

/* sv/percentage_error_accumulator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// percentage_error_accumulator
// mean (symmetric) absolute percentage error over a series of sample pairs
// ----------------------------------------------------------------------------
// one word per sample pair; each used sample runs one serial divide of
// max(33 + FRAC_BITS, 55) steps
// the series-end word adds a second divide of the same width for the mean
// a 2-deep queue lets the front keep taking words while the back divides
// synchronous active-high reset clears the accumulators, queue, fsm and mode
module percentage_error_accumulator import pea_pkg::*; #(
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // configuration, metric mode
   input  wire logic                     csr_wr_en,
   input  wire logic                     csr_wr_data,
   // sample pair words
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [DATA_W-1:0] req_actual_value,
   input  wire logic signed [DATA_W-1:0] req_predicted_value,
   input  wire logic                     req_series_end,
   // result words
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [PCT_W-1:0]              rsp_error_percent,
   output logic                          rsp_result_defined,
   output logic [COUNT_OUT_W-1:0]        rsp_samples_used
);

   logic       metric_mode_ff;
   sample_type front_sample;
   sample_type queue_sample;
   logic       q_full;
   logic       q_not_empty;
   logic       q_pop;
   logic       req_accept;

   // mode register; the user must write it only between series, unchecked
   always_ff @(posedge clock) begin
      if (reset) begin
         metric_mode_ff <= MODE_PLAIN;
      end else if (csr_wr_en) begin
         metric_mode_ff <= csr_wr_data;
      end
   end

   // front: magnitudes and zero-denominator classification
   pea_front u_front (
      .metric_mode     (metric_mode_ff),
      .actual_value    (req_actual_value),
      .predicted_value (req_predicted_value),
      .series_end      (req_series_end),
      .sample          (front_sample)
   );

   assign req_ready  = !q_full;
   assign req_accept = req_valid && req_ready;

   // decoupling queue
   pea_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_sample),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (queue_sample)
   );

   // back: ratio divide, accumulate, mean divide, result register
   pea_back #(
      .FRAC_BITS   (FRAC_BITS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_data             (queue_sample),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_error_percent  (rsp_error_percent),
      .rsp_result_defined (rsp_result_defined),
      .rsp_samples_used   (rsp_samples_used)
   );

endmodule

`default_nettype wire
